// ----- rtl/sorted_table_engine_macros.svh -----
// Assertion macros for the sorted table engine.
`ifndef SORTED_TABLE_ENGINE_MACROS_SVH
`define SORTED_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ste_pkg.sv -----
// Shared types and codes for the sorted table engine.
`timescale 1ns / 1ps

package ste_pkg;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [INDEX_W-1:0]  index;
		logic [STATUS_W-1:0] status;
	} ste_result_t;

endpackage

// ----- rtl/ste_cmp.sv -----
// Shared signed compare unit used by every search step and match check.
`timescale 1ns / 1ps

module ste_cmp
	import ste_pkg::*;
(
	input  logic signed [VALUE_W-1:0] a,
	input  logic signed [VALUE_W-1:0] b,
	output logic                      lt,
	output logic                      eq
);

	assign lt = a < b;
	assign eq = a == b;

endmodule

// ----- rtl/ste_ram.sv -----
// Table storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ste_ram
	import ste_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/ste_seq.sv -----
// Sequencer: binary search, match check and one-entry-per-cycle shift.
`timescale 1ns / 1ps

module ste_seq
	import ste_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    in_op,
	input  logic [VALUE_W-1:0] in_value,
	output logic               res_valid,
	input  logic               res_ready,
	output ste_result_t        res,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [VALUE_W-1:0] wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [VALUE_W-1:0] rd_data
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SRCH_RD  = 3'd1;
	localparam logic [2:0] S_SRCH_CMP = 3'd2;
	localparam logic [2:0] S_CHK_CMP  = 3'd3;
	localparam logic [2:0] S_SHIFT    = 3'd4;
	localparam logic [2:0] S_PLACE    = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [VALUE_W-1:0]  val_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       mid_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       i_q;
	logic [AW-1:0]       wa_q;
	logic                pend_q;
	logic [CW-1:0]       count_q;
	logic [STATUS_W-1:0] status_q;

	logic          ins;
	logic [CW-1:0] mid;
	logic          sh_more;
	logic [CW-1:0] sh_src;
	logic [CW-1:0] sh_dst;
	logic          cmp_lt;
	logic          cmp_eq;
	logic          go_right;

	ste_cmp u_cmp (
		.a  (rd_data),
		.b  (val_q),
		.lt (cmp_lt),
		.eq (cmp_eq)
	);

	always_comb begin
		ins      = op_q == OP_INSERT;
		mid      = lo_q + ((hi_q - lo_q) >> 1);
		sh_more  = ins ? (i_q > pos_q) : (i_q < count_q);
		sh_src   = ins ? (i_q - CW'(1)) : i_q;
		sh_dst   = ins ? i_q : (i_q - CW'(1));
		// insert lands after equal entries, delete/search stop at the first
		go_right = ins ? (cmp_lt | cmp_eq) : cmp_lt;

		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			S_SRCH_RD: begin
				rd_en   = 1'b1;
				rd_addr = (lo_q < hi_q) ? mid[AW-1:0] : lo_q[AW-1:0];
			end
			S_SHIFT: begin
				rd_en   = sh_more;
				rd_addr = sh_src[AW-1:0];
				wr_en   = pend_q;
				wr_addr = wa_q;
				wr_data = rd_data;
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (in_valid) begin
						op_q  <= in_op;
						val_q <= in_value;
						lo_q  <= '0;
						hi_q  <= count_q;
						if (in_op == OP_INSERT && count_q >= CW'(TABLE_DEPTH)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (in_op == OP_INSERT || in_op == OP_DELETE ||
						             in_op == OP_SEARCH) begin
							state_q <= S_SRCH_RD;
						end else begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_DONE;
						end
					end
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						pos_q <= lo_q;
						if (ins) begin
							i_q     <= count_q;
							state_q <= S_SHIFT;
						end else if (lo_q < count_q) begin
							state_q <= S_CHK_CMP;
						end else begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_DONE;
						end
					end
				end
				S_SRCH_CMP: begin
					if (go_right) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH_RD;
				end
				S_CHK_CMP: begin
					if (cmp_eq) begin
						status_q <= ST_OK;
						if (op_q == OP_DELETE) begin
							i_q     <= pos_q + CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end
				end
				S_SHIFT: begin
					// read one entry ahead, write it back one place over next cycle
					pend_q <= sh_more;
					if (sh_more) begin
						wa_q <= sh_dst[AW-1:0];
						i_q  <= ins ? (i_q - CW'(1)) : (i_q + CW'(1));
					end else if (ins) begin
						state_q <= S_PLACE;
					end else begin
						count_q  <= count_q - CW'(1);
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end
				end
				S_PLACE: begin
					pend_q   <= 1'b0;
					count_q  <= count_q + CW'(1);
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = state_q == S_IDLE;
	assign res_valid  = state_q == S_DONE;
	assign res.status = status_q;
	assign res.index  = (status_q == ST_OK) ? INDEX_W'(pos_q) : '0;
	assign res.count  = COUNT_W'(count_q);

endmodule

// ----- rtl/sorted_table_engine.sv -----
// Top level of the sorted table engine: storage, sequencer and result register.
`timescale 1ns / 1ps
`include "sorted_table_engine_macros.svh"

// Keeps up to TABLE_DEPTH signed 32-bit values in ascending order and runs one
// request at a time: insert (placed after equal entries), delete or search
// (both on the lowest equal entry). A request runs a binary search that shares
// one compare unit over a table with one read and one write port, then, for
// an insert or delete, a shift that moves one entry per cycle. An insert into
// a full table or an undefined op code goes straight to the result. The block
// takes no new request until the current one has been handed to the result
// register.
module sorted_table_engine
	import ste_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // op[1:0], value[33:2], zero[39:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // status[1:0], index[7:2], count[14:8], zero[15]
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;
	logic               res_valid;
	logic               res_ready;
	ste_result_t        res;
	ste_result_t        res_q;
	logic               m_valid_q;

	ste_ram #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ste_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tdata[OP_W-1:0]),
		.in_value  (s_axis_tdata[OP_W+VALUE_W-1:OP_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// load a new result whenever the output slot is empty or being drained
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};

	`STE_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, m_axis_tvalid, "result lost on load")
	`STE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
	`STE_ASSERT_IMPL(a_full_count, m_axis_tvalid && res_q.status == ST_FULL, res_q.count == COUNT_W'(TABLE_DEPTH), "table full reported below capacity")
	`STE_ASSERT_IMPL(a_index_zero, m_axis_tvalid && res_q.status != ST_OK, res_q.index == '0, "index set on failed request")

endmodule
